[design/pmlf_pkg.sv]
// Package for the page map block: field widths, register indexes, reset values,
// the state and cell-mode enums, and the control struct the cells share.
// No dependencies.
`default_nettype none

package pmlf_pkg;

  localparam int DEF_MAX_FRAMES = 16;
  localparam int DEF_ADDR_WIDTH = 32;

  localparam int FRAME_W = 4;
  localparam int FC_W    = 5;
  localparam int PSIZE_W = 21;
  localparam int OFFS_W  = 20;
  localparam int PA_W    = 24;
  localparam int PROD_W  = FRAME_W + PSIZE_W;
  localparam int CFG_IDX_W = 2;

  localparam logic [PSIZE_W-1:0] PSIZE_MAX   = PSIZE_W'(1048576);
  localparam logic [PSIZE_W-1:0] PSIZE_RESET = PSIZE_W'(4096);
  localparam int                 FC_RESET    = 16;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_COUNT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAGE_SIZE      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REPLACE_POLICY = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_CMP,
    ST_UPD,
    ST_FIN
  } pmlf_state_e;

  typedef enum logic [2:0] {
    MODE_HOLD,
    MODE_FRONT_HIT,
    MODE_FRONT_NEW,
    MODE_FRONT_LAST,
    MODE_ROTATE,
    MODE_APPEND
  } pmlf_mode_e;

  typedef struct packed {
    pmlf_mode_e         mode;
    logic               cmp_en;
    logic [FRAME_W-1:0] load_frame;
  } pmlf_ctrl_t;

endpackage

`default_nettype wire

[design/pmlf_div.sv]
// Bit-serial restoring divider: address by page size, one quotient bit per cycle.
// Depends on pmlf_pkg.
`default_nettype none

module pmlf_div #(
  parameter int AW = pmlf_pkg::DEF_ADDR_WIDTH
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [AW-1:0]              dividend_i,
  input  wire logic [pmlf_pkg::PSIZE_W-1:0] divisor_i,
  output logic                            done_o,
  output logic [AW-1:0]                   quot_o,
  output logic [pmlf_pkg::OFFS_W-1:0]     rem_o
);
  import pmlf_pkg::*;

  localparam int CW = $clog2(AW + 1);

  logic [AW-1:0]      quot_q, quot_d;
  logic [OFFS_W-1:0]  rem_q, rem_d;
  logic [CW-1:0]      cnt_q, cnt_d;
  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [PSIZE_W-1:0] rem_sh;
  logic [PSIZE_W-1:0] rem_sub;
  logic               ge;

  always_comb begin
    rem_sh  = {rem_q, quot_q[AW-1]};
    ge      = rem_sh >= divisor_i;
    rem_sub = rem_sh - divisor_i;
  end

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      quot_d = dividend_i;
      rem_d  = '0;
      cnt_d  = CW'(AW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      quot_d = {quot_q[AW-2:0], ge};
      rem_d  = ge ? rem_sub[OFFS_W-1:0] : rem_sh[OFFS_W-1:0];
      cnt_d  = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

[design/pmlf_cell.sv]
// One table cell: a page and frame pair, its registered tag match, and the
// hit and frame-select chains that run through the row. Depends on pmlf_pkg.
`default_nettype none

module pmlf_cell #(
  parameter int IDX    = 0,
  parameter int PAGE_W = pmlf_pkg::DEF_ADDR_WIDTH,
  parameter int CNT_W  = 5
) (
  input  wire logic                         clk_i,
  input  wire pmlf_pkg::pmlf_ctrl_t         ctrl_i,
  input  wire logic [CNT_W-1:0]             filled_i,
  input  wire logic [PAGE_W-1:0]            page_i,
  input  wire logic [PAGE_W-1:0]            left_page_i,
  input  wire logic [pmlf_pkg::FRAME_W-1:0] left_frame_i,
  input  wire logic [PAGE_W-1:0]            right_page_i,
  input  wire logic [pmlf_pkg::FRAME_W-1:0] right_frame_i,
  input  wire logic                         above_i,
  input  wire logic [pmlf_pkg::FRAME_W-1:0] hit_frame_i,
  input  wire logic [pmlf_pkg::FRAME_W-1:0] last_frame_i,
  output logic                              below_o,
  output logic [pmlf_pkg::FRAME_W-1:0]      hit_frame_o,
  output logic [pmlf_pkg::FRAME_W-1:0]      last_frame_o,
  output logic [PAGE_W-1:0]                 page_o,
  output logic [pmlf_pkg::FRAME_W-1:0]      frame_o
);
  import pmlf_pkg::*;

  localparam logic [CNT_W-1:0] MY_IDX  = CNT_W'(IDX);
  localparam logic [CNT_W-1:0] MY_NEXT = CNT_W'(IDX + 1);

  logic [PAGE_W-1:0]  page_q, page_d;
  logic [FRAME_W-1:0] frame_q, frame_d;
  logic               match_q, match_d;
  logic               hit_last;
  logic               is_last;
  logic               do_load, do_left, do_right;

  always_comb begin
    hit_last     = match_q & ~above_i;
    is_last      = MY_NEXT == filled_i;
    below_o      = above_i | match_q;
    hit_frame_o  = hit_frame_i | (hit_last ? frame_q : '0);
    last_frame_o = last_frame_i | (is_last ? frame_q : '0);
  end

  always_comb begin
    do_load  = 1'b0;
    do_left  = 1'b0;
    do_right = 1'b0;
    unique case (ctrl_i.mode)
      MODE_HOLD: ;
      MODE_FRONT_HIT: begin
        do_load = IDX == 0;
        do_left = IDX != 0 && below_o;
      end
      MODE_FRONT_NEW: begin
        do_load = IDX == 0;
        do_left = IDX != 0 && MY_IDX <= filled_i;
      end
      MODE_FRONT_LAST: begin
        do_load = IDX == 0;
        do_left = IDX != 0 && MY_IDX < filled_i;
      end
      MODE_ROTATE: begin
        do_load  = is_last;
        do_right = MY_NEXT < filled_i;
      end
      MODE_APPEND: begin
        do_load = MY_IDX == filled_i;
      end
      default: ;
    endcase
  end

  always_comb begin
    page_d  = page_q;
    frame_d = frame_q;
    match_d = match_q;
    if (ctrl_i.cmp_en) begin
      match_d = (MY_IDX < filled_i) && (page_q == page_i);
    end
    if (do_load) begin
      page_d  = page_i;
      frame_d = ctrl_i.load_frame;
    end else if (do_left) begin
      page_d  = left_page_i;
      frame_d = left_frame_i;
    end else if (do_right) begin
      page_d  = right_page_i;
      frame_d = right_frame_i;
    end
  end

  always_ff @(posedge clk_i) begin
    page_q  <= page_d;
    frame_q <= frame_d;
    match_q <= match_d;
  end

  assign page_o  = page_q;
  assign frame_o = frame_q;

endmodule

`default_nettype wire

[design/page_map_lru_fifo_top.sv]
// Top level of the page map: config registers, sequencer, divider and cell row.
// Depends on pmlf_pkg, pmlf_div and pmlf_cell.
//
//   channel | signals                          | direction
//   in      | in_valid_i, in_stall_o           | address in
//   out     | out_valid_o, out_stall_i         | translation out
//   cfg     | cfg_valid_i, cfg_ready_o         | register write
//
// A result loads after its accept through these steps in order: ADDR_WIDTH divider steps (one
// quotient bit each), divider done, tag compare, table update, output load.
// The next address is taken in the cycle after the load; addresses are not overlapped.
// Hold the load while the output register is stalled; once loaded, a new address is taken.
// Reset empties the table and loads frame_count 16 (capped at MAX_FRAMES), page_size 4096, LRU.
// Any known register write empties the table.
`default_nettype none

module page_map_lru_fifo_top #(
  parameter int MAX_FRAMES = pmlf_pkg::DEF_MAX_FRAMES,
  parameter int ADDR_WIDTH = pmlf_pkg::DEF_ADDR_WIDTH
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire logic [ADDR_WIDTH-1:0]            virtual_address_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output logic                                  page_fault_o,
  output logic [pmlf_pkg::PA_W-1:0]             physical_address_o,
  output logic [pmlf_pkg::FRAME_W-1:0]          frame_used_o,
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [pmlf_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [pmlf_pkg::PSIZE_W-1:0]     cfg_data_i
);
  import pmlf_pkg::*;

  localparam int CNT_W = $clog2(MAX_FRAMES + 1);
  localparam int FC_RESET_EFF = (FC_RESET > MAX_FRAMES) ? MAX_FRAMES : FC_RESET;

  pmlf_state_e state_q, state_d;

  logic [CNT_W-1:0]   frame_count_q, frame_count_d;
  logic [PSIZE_W-1:0] page_size_q, page_size_d;
  logic               fifo_q, fifo_d;
  logic [CNT_W-1:0]   filled_q, filled_d;

  logic               div_start, div_done;
  logic [ADDR_WIDTH-1:0] page;
  logic [OFFS_W-1:0]  offset;

  logic               cmp_en, upd_en, fin_load, out_busy;
  pmlf_ctrl_t         ctrl;
  pmlf_mode_e         mode_sel;
  logic [FRAME_W-1:0] frame_sel;
  logic               found, full;

  logic               fault_q;
  logic [FRAME_W-1:0] frame_q;

  logic               out_valid_q, out_valid_d;
  logic               out_fault_q;
  logic [PA_W-1:0]    out_pa_q;
  logic [FRAME_W-1:0] out_frame_q;
  logic [PROD_W-1:0]  pa_full;

  logic [ADDR_WIDTH-1:0] pg [MAX_FRAMES];
  logic [FRAME_W-1:0]    fr [MAX_FRAMES];
  logic                  below [MAX_FRAMES+1];
  logic [FRAME_W-1:0]    hit_fr [MAX_FRAMES+1];
  logic [FRAME_W-1:0]    last_fr [MAX_FRAMES+1];

  logic [FC_W-1:0]    fc_raw;
  logic               cfg_we, cfg_known;

  // configuration
  always_comb begin
    cfg_we        = cfg_valid_i & cfg_ready_o;
    fc_raw        = cfg_data_i[FC_W-1:0];
    frame_count_d = frame_count_q;
    page_size_d   = page_size_q;
    fifo_d        = fifo_q;
    cfg_known     = 1'b0;
    if (cfg_we) begin
      unique case (cfg_index_i)
        REG_FRAME_COUNT: begin
          cfg_known = 1'b1;
          if (fc_raw == '0) begin
            frame_count_d = CNT_W'(1);
          end else if (32'(fc_raw) > MAX_FRAMES) begin
            frame_count_d = CNT_W'(MAX_FRAMES);
          end else begin
            frame_count_d = CNT_W'(fc_raw);
          end
        end
        REG_PAGE_SIZE: begin
          cfg_known = 1'b1;
          if (cfg_data_i == '0) begin
            page_size_d = PSIZE_W'(1);
          end else if (cfg_data_i > PSIZE_MAX) begin
            page_size_d = PSIZE_MAX;
          end else begin
            page_size_d = cfg_data_i;
          end
        end
        REG_REPLACE_POLICY: begin
          cfg_known = 1'b1;
          fifo_d    = cfg_data_i[0];
        end
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  // sequencer: next state
  always_comb begin
    out_busy = out_valid_q & out_stall_i;
    state_d  = state_q;
    unique case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_DIV;
      ST_DIV:  if (div_done) state_d = ST_CMP;
      ST_CMP:  state_d = ST_UPD;
      ST_UPD:  state_d = ST_FIN;
      ST_FIN:  if (!out_busy) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // sequencer: outputs
  always_comb begin
    in_stall_o = 1'b1;
    div_start  = 1'b0;
    cmp_en     = 1'b0;
    upd_en     = 1'b0;
    fin_load   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        div_start  = in_valid_i;
      end
      ST_DIV: ;
      ST_CMP: cmp_en = 1'b1;
      ST_UPD: upd_en = 1'b1;
      ST_FIN: fin_load = ~out_busy;
      default: ;
    endcase
  end

  // replacement decision
  always_comb begin
    found = below[0];
    full  = filled_q >= frame_count_q;
    if (found) begin
      mode_sel  = fifo_q ? MODE_HOLD : MODE_FRONT_HIT;
      frame_sel = hit_fr[0];
    end else if (!full) begin
      mode_sel  = fifo_q ? MODE_APPEND : MODE_FRONT_NEW;
      frame_sel = FRAME_W'(filled_q);
    end else if (fifo_q) begin
      mode_sel  = MODE_ROTATE;
      frame_sel = fr[0];
    end else begin
      mode_sel  = MODE_FRONT_LAST;
      frame_sel = last_fr[0];
    end
    ctrl.mode       = upd_en ? mode_sel : MODE_HOLD;
    ctrl.cmp_en     = cmp_en;
    ctrl.load_frame = frame_sel;
  end

  always_comb begin
    filled_d = filled_q;
    if (cfg_known) begin
      filled_d = '0;
    end else if (upd_en && !found && !full) begin
      filled_d = filled_q + CNT_W'(1);
    end
  end

  always_comb begin
    pa_full     = PROD_W'(frame_q) * PROD_W'(page_size_q) + PROD_W'(offset);
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (fin_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      frame_count_q <= CNT_W'(FC_RESET_EFF);
      page_size_q   <= PSIZE_RESET;
      fifo_q        <= 1'b0;
      filled_q      <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      frame_count_q <= frame_count_d;
      page_size_q   <= page_size_d;
      fifo_q        <= fifo_d;
      filled_q      <= filled_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd_en) begin
      fault_q <= ~found;
      frame_q <= frame_sel;
    end
    if (fin_load) begin
      out_fault_q <= fault_q;
      out_pa_q    <= fault_q ? '0 : pa_full[PA_W-1:0];
      out_frame_q <= frame_q;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign page_fault_o        = out_fault_q;
  assign physical_address_o  = out_pa_q;
  assign frame_used_o        = out_frame_q;

  pmlf_div #(
    .AW(ADDR_WIDTH)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (virtual_address_i),
    .divisor_i  (page_size_q),
    .done_o     (div_done),
    .quot_o     (page),
    .rem_o      (offset)
  );

  assign below[MAX_FRAMES]   = 1'b0;
  assign hit_fr[MAX_FRAMES]  = '0;
  assign last_fr[MAX_FRAMES] = '0;

  for (genvar i = 0; i < MAX_FRAMES; i++) begin : g_cell
    logic [ADDR_WIDTH-1:0] lpg, rpg;
    logic [FRAME_W-1:0]    lfr, rfr;

    if (i == 0) begin : g_first
      assign lpg = '0;
      assign lfr = '0;
    end else begin : g_mid_l
      assign lpg = pg[i-1];
      assign lfr = fr[i-1];
    end

    if (i == MAX_FRAMES - 1) begin : g_last
      assign rpg = '0;
      assign rfr = '0;
    end else begin : g_mid_r
      assign rpg = pg[i+1];
      assign rfr = fr[i+1];
    end

    pmlf_cell #(
      .IDX    (i),
      .PAGE_W (ADDR_WIDTH),
      .CNT_W  (CNT_W)
    ) u_cell (
      .clk_i         (clk_i),
      .ctrl_i        (ctrl),
      .filled_i      (filled_q),
      .page_i        (page),
      .left_page_i   (lpg),
      .left_frame_i  (lfr),
      .right_page_i  (rpg),
      .right_frame_i (rfr),
      .above_i       (below[i+1]),
      .hit_frame_i   (hit_fr[i+1]),
      .last_frame_i  (last_fr[i+1]),
      .below_o       (below[i]),
      .hit_frame_o   (hit_fr[i]),
      .last_frame_o  (last_fr[i]),
      .page_o        (pg[i]),
      .frame_o       (fr[i])
    );
  end

endmodule

`default_nettype wire

[design/pmlf_checker.sv]
// Port-level checks for the page map top level, bound to it below.
// Depends on pmlf_pkg.
`default_nettype none

module pmlf_checker #(
  parameter int ADDR_WIDTH = pmlf_pkg::DEF_ADDR_WIDTH
) (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           in_valid_i,
  input wire logic                           in_stall_o,
  input wire logic                           out_valid_o,
  input wire logic                           out_stall_i,
  input wire logic                           page_fault_o,
  input wire logic [pmlf_pkg::PA_W-1:0]      physical_address_o,
  input wire logic [pmlf_pkg::FRAME_W-1:0]   frame_used_o
);
  import pmlf_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(physical_address_o)
      && $stable(page_fault_o) && $stable(frame_used_o))
    else $error("output transfer changed while stalled");

  a_fault_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && page_fault_o |-> physical_address_o == '0)
    else $error("fault carries nonzero address");

  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken again while translation in flight");

  a_result_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without work in flight");

endmodule

bind page_map_lru_fifo_top pmlf_checker #(.ADDR_WIDTH(ADDR_WIDTH)) u_pmlf_checker (.*);

`default_nettype wire
